// ----- rtl/dpfa_pkg.sv -----
// Shared constants and types for the demand page frame allocator.
// No dependencies; every rtl module imports this package.
package dpfa_pkg;

  // Region geometry. PAGE_BYTES is a power of two; the page index is a shift.
  localparam int unsigned PAGE_COUNT = 512;
  localparam int unsigned PAGE_BYTES = 4096;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned FRAME_W = 9;
  localparam int unsigned PAGE_W  = $clog2(PAGE_COUNT);
  localparam int unsigned OFS_W   = $clog2(PAGE_BYTES);
  localparam int unsigned CNT_W   = $clog2(PAGE_COUNT + 1);
  localparam int unsigned PFULL_W = ADDR_W - OFS_W;

  // Result codes
  typedef enum logic [1:0] {
    ST_SUCCESS   = 2'd0,
    ST_VIOLATION = 2'd1,
    ST_NO_FRAMES = 2'd2
  } status_e;

  // One page table entry
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  // Access request from the control logic to the page table
  typedef struct packed {
    logic              rd_en;
    logic [PAGE_W-1:0] rd_addr;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
    pte_t              wr_data;
  } pt_req_t;

endpackage

// ----- rtl/dpfa_page_table.sv -----
// Page table memory: one entry per page, registered read, one write port.
// Runs a clearing pass after reset. Depends on dpfa_pkg.
module dpfa_page_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dpfa_pkg::pt_req_t req_i,
  output dpfa_pkg::pte_t    rd_data_o,
  output logic              init_done_o
);
  import dpfa_pkg::*;

  pte_t              mem_q [PAGE_COUNT];
  pte_t              rd_data_q;
  logic              clr_busy_q, clr_busy_d;
  logic [PAGE_W-1:0] clr_addr_q, clr_addr_d;
  logic              clr_last;
  logic              wr_en;
  logic [PAGE_W-1:0] wr_addr;
  pte_t              wr_data;

  // Clearing pass walks every entry once after reset
  assign clr_last = (clr_addr_q == PAGE_W'(PAGE_COUNT - 1));

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + PAGE_W'(1);
      if (clr_last) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Write port: clearing pass has priority (no requests arrive meanwhile)
  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = req_i.wr_en;
      wr_addr = req_i.wr_addr;
      wr_data = req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o   = rd_data_q;
  assign init_done_o = !clr_busy_q;

  // No accesses from the control side while clearing
  a_no_req_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!req_i.rd_en && !req_i.wr_en))
    else $error("page table access during clearing pass");

  // Clearing pass ends exactly after the last entry
  a_clear_ends_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> $past(clr_last))
    else $error("clearing pass ended early");

  // Read and write never target the same cycle (control interlock)
  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.rd_en && req_i.wr_en))
    else $error("overlapping read and write of page table");

endmodule

// ----- rtl/dpfa_free_list.sv -----
// Free frame stack. Frames are never returned, so entry i always holds
// frame i and the stack reduces to its fill count. Depends on dpfa_pkg.
module dpfa_free_list (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [dpfa_pkg::FRAME_W-1:0]  top_frame_o
);
  import dpfa_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;

  // Top of stack is entry count - 1, which holds that frame number
  assign empty_o     = (count_q == '0);
  assign top_frame_o = FRAME_W'(count_q - CNT_W'(1));

  always_comb begin
    count_d = count_q;
    if (pop_i && !empty_o) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(PAGE_COUNT);
    end else begin
      count_q <= count_d;
    end
  end

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty free list");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(PAGE_COUNT))
    else $error("free count above frame total");

  a_pop_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("free count did not drop on pop");

endmodule

// ----- rtl/demand_page_frame_allocator_unit.sv -----
// Each address word is handled in two steps: the first range-checks it and
// reads its page table entry (synchronous memory, registered read), the
// second, once the output register is free, decides, writes back a new
// mapping and loads the result register, after which the next word is taken.
// After reset the page table is cleared one entry a cycle, so the input is
// not ready until all PAGE_COUNT entries are clear; region_base writes are
// taken at any time. Frames are handed out from 511 downward and never freed.
module demand_page_frame_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          region_base_we_i,
  input  logic [dpfa_pkg::ADDR_W-1:0]   region_base_i,
  // request words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dpfa_pkg::ADDR_W-1:0]   virtual_address_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dpfa_pkg::status_e             status_o,
  output logic [dpfa_pkg::FRAME_W-1:0]  frame_number_o,
  output logic                          already_mapped_o
);
  import dpfa_pkg::*;

  logic [ADDR_W-1:0]  region_base_q;
  logic               busy_q, busy_d;
  logic               viol_q;
  logic [PAGE_W-1:0]  page_q;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               mapped_q, mapped_d;

  logic               accept;
  logic               finish;
  logic [ADDR_W:0]    diff;
  logic [PFULL_W-1:0] page_full;
  logic               viol_d;
  logic [PAGE_W-1:0]  page_d;

  pt_req_t            pt_req;
  pte_t               pte;
  logic               init_done;
  logic               fl_pop;
  logic               fl_empty;
  logic [FRAME_W-1:0] fl_top;

  dpfa_page_table u_page_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (pt_req),
    .rd_data_o   (pte),
    .init_done_o (init_done)
  );

  dpfa_free_list u_free_list (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (fl_pop),
    .empty_o     (fl_empty),
    .top_frame_o (fl_top)
  );

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= '0;
    end else if (region_base_we_i) begin
      region_base_q <= region_base_i;
    end
  end

  // Range check: offset from base, borrow flags below-base addresses
  assign diff      = {1'b0, virtual_address_i} - {1'b0, region_base_q};
  assign page_full = diff[ADDR_W-1:OFS_W];
  assign viol_d    = diff[ADDR_W] || (page_full >= PFULL_W'(PAGE_COUNT));
  assign page_d    = page_full[PAGE_W-1:0];

  assign in_ready_o = !busy_q && init_done;
  assign accept     = in_valid_i && in_ready_o;
  assign finish     = busy_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      viol_q <= viol_d;
      page_q <= page_d;
    end
  end

  // Decide, write back and build the result
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    frame_d     = frame_q;
    mapped_d    = mapped_q;
    fl_pop      = 1'b0;

    pt_req         = '0;
    pt_req.rd_en   = accept && !viol_d;
    pt_req.rd_addr = page_d;
    pt_req.wr_addr = page_q;
    pt_req.wr_data = '{valid: 1'b1, frame: fl_top};

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
    end
    if (finish) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      frame_d     = '0;
      mapped_d    = 1'b0;
      if (viol_q) begin
        status_d = ST_VIOLATION;
      end else if (pte.valid) begin
        status_d = ST_SUCCESS;
        frame_d  = pte.frame;
        mapped_d = 1'b1;
      end else if (fl_empty) begin
        status_d = ST_NO_FRAMES;
      end else begin
        status_d     = ST_SUCCESS;
        frame_d      = fl_top;
        fl_pop       = 1'b1;
        pt_req.wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q <= status_d;
      frame_q  <= frame_d;
      mapped_q <= mapped_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign frame_number_o   = frame_q;
  assign already_mapped_o = mapped_q;

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> !in_ready_o)
    else $error("input ready during clearing pass");

  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("result word without a word in flight");

  a_stall_holds_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_valid_q && !out_ready_i) |=> busy_q)
    else $error("word in flight dropped while output stalled");

  a_map_only_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_req.wr_en |-> (busy_q && !viol_q && fl_pop))
    else $error("page mapped without a valid in-range allocation");

endmodule
